FILE: hdl/bpc_pkg.sv
// ---------------------------------------------------------------------------
// bpc_pkg: shared types and constants
// Key modes, outcome codes, config register map and the structs that pass
// between the button press classifier modules.
// ---------------------------------------------------------------------------
package bpc_pkg;

  localparam int MAX_SLOTS    = 4;
  localparam int SLOT_W       = 2;
  localparam int SLOT_COUNT_W = 3;
  localparam int DEBOUNCE_W   = 16;
  localparam int THR_W        = 24;
  localparam int TIME_W       = 32;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 24;

  // config register map
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_MASK  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_MASK  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_THR_ZERO   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_THR_ONE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_THR_TWO    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_THR_THREE  = 3'd7;

  // item kinds
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_DEBOUNCE = 2'd2,
    MODE_HANDLED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_FIRED   = 2'd1,
    OUT_IGNORED = 2'd2,
    OUT_NO_SLOT = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0]              debounce_time;
    logic [SLOT_COUNT_W-1:0]            slot_count;
    logic [MAX_SLOTS-1:0]               long_mask;
    logic [MAX_SLOTS-1:0]               exit_mask;
    logic [MAX_SLOTS-1:0][THR_W-1:0]    thr;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
    logic              exit_req;
    logic              last_long;
    logic [THR_W-1:0]  last_thr;
  } pick_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot_index;
    logic              exit_request;
    logic [TIME_W-1:0] hold_duration;
    logic              wakeup_pending;
    mode_t             key_mode_out;
  } result_t;

endpackage

FILE: hdl/bpc_ifs.sv
// ---------------------------------------------------------------------------
// bpc_ifs: stream channels
// Valid/ready channels for key/tick items and for classifier results.
// ---------------------------------------------------------------------------
interface bpc_item_if;
  logic valid;
  logic ready;
  logic action;
  logic key_level;

  modport source (output valid, action, key_level, input ready);
  modport sink   (input valid, action, key_level, output ready);
endinterface

interface bpc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [1:0]  slot_index;
  logic        exit_request;
  logic [31:0] hold_duration;
  logic        wakeup_pending;
  logic [1:0]  key_mode_out;

  modport source (output valid, outcome, slot_index, exit_request, hold_duration,
                  wakeup_pending, key_mode_out, input ready);
  modport sink   (input valid, outcome, slot_index, exit_request, hold_duration,
                  wakeup_pending, key_mode_out, output ready);
endinterface

FILE: hdl/button_press_classifier.sv
// ---------------------------------------------------------------------------
// button_press_classifier: short/long press detector for one key
// Input register, single-pass step logic, result register; one result
// beat for every item beat.
// ---------------------------------------------------------------------------
//
//   channel  dir  beat contents                         handshake
//   -------  ---  ------------------------------------  -----------
//   item     in   action, key_level                     valid/ready
//   result   out  outcome, slot_index, exit_request,    valid/ready
//                 hold_duration, wakeup_pending,
//                 key_mode_out
//   cfg      in   cfg_index, cfg_data                   cfg_we only
//
// One item per cycle sustained while the result side takes beats. An item
// waits in the input register, then the step logic (one add/subtract
// chain and four parallel threshold compares) commits state and loads
// the result register.
// Reset (rst, synchronous) clears key mode, time, wakeup and both valids;
// config returns to its defaults. Stamps are written before any use.
// A stalled result holds; the input register still takes one more item.
//
module button_press_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  bpc_item_if.sink                          item,
  bpc_result_if.source                      result
);

  bpc_pkg::cfg_t    cfg;
  bpc_pkg::result_t step_res;
  bpc_pkg::result_t res_q;

  // input register
  logic item_valid_q;
  logic action_q;
  logic key_level_q;

  logic res_valid;
  logic advance;

  // step fires when an item is waiting and the result slot is free or draining
  assign advance    = item_valid_q && (!res_valid || result.ready);
  assign item.ready = !item_valid_q || advance;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_step u_step (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .action    (action_q),
    .key_level (key_level_q),
    .cfg       (cfg),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid_q <= 1'b0;
    end else if (item.ready) begin
      item_valid_q <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      action_q    <= item.action;
      key_level_q <= item.key_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign result.valid          = res_valid;
  assign result.outcome        = res_q.outcome;
  assign result.slot_index     = res_q.slot_index;
  assign result.exit_request   = res_q.exit_request;
  assign result.hold_duration  = res_q.hold_duration;
  assign result.wakeup_pending = res_q.wakeup_pending;
  assign result.key_mode_out   = res_q.key_mode_out;

endmodule

FILE: hdl/bpc_cfg_regs.sv
// ---------------------------------------------------------------------------
// bpc_cfg_regs: configuration register file
// Write-only registers for debounce time, slot setup and thresholds.
// ---------------------------------------------------------------------------
module bpc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bpc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= bpc_pkg::DEBOUNCE_W'(50);
      cfg.slot_count    <= bpc_pkg::SLOT_COUNT_W'(1);
      cfg.long_mask     <= '0;
      cfg.exit_mask     <= '0;
      cfg.thr[0]        <= bpc_pkg::THR_W'(1000);
      cfg.thr[1]        <= '0;
      cfg.thr[2]        <= '0;
      cfg.thr[3]        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::CFG_DEBOUNCE:   cfg.debounce_time <= cfg_data[bpc_pkg::DEBOUNCE_W-1:0];
        bpc_pkg::CFG_SLOT_COUNT: cfg.slot_count <= cfg_data[bpc_pkg::SLOT_COUNT_W-1:0];
        bpc_pkg::CFG_LONG_MASK:  cfg.long_mask <= cfg_data[bpc_pkg::MAX_SLOTS-1:0];
        bpc_pkg::CFG_EXIT_MASK:  cfg.exit_mask <= cfg_data[bpc_pkg::MAX_SLOTS-1:0];
        bpc_pkg::CFG_THR_ZERO:   cfg.thr[0] <= cfg_data[bpc_pkg::THR_W-1:0];
        bpc_pkg::CFG_THR_ONE:    cfg.thr[1] <= cfg_data[bpc_pkg::THR_W-1:0];
        bpc_pkg::CFG_THR_TWO:    cfg.thr[2] <= cfg_data[bpc_pkg::THR_W-1:0];
        bpc_pkg::CFG_THR_THREE:  cfg.thr[3] <= cfg_data[bpc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/bpc_slot_pick.sv
// ---------------------------------------------------------------------------
// bpc_slot_pick: slot selection
// Parallel threshold compares; short slots ascending, then long slots
// descending. Also reports the last slot in use for press arming.
// ---------------------------------------------------------------------------
module bpc_slot_pick (
  input  bpc_pkg::cfg_t                 cfg,
  input  logic [bpc_pkg::TIME_W-1:0]    hold,
  output bpc_pkg::pick_t                pick
);

  logic [bpc_pkg::SLOT_COUNT_W-1:0] n;
  logic [bpc_pkg::SLOT_W-1:0]       last;
  logic [bpc_pkg::MAX_SLOTS-1:0]    below;

  // clamp slot count to 1..MAX_SLOTS
  always_comb begin
    if (cfg.slot_count == '0) begin
      n = bpc_pkg::SLOT_COUNT_W'(1);
    end else if (cfg.slot_count > bpc_pkg::SLOT_COUNT_W'(bpc_pkg::MAX_SLOTS)) begin
      n = bpc_pkg::SLOT_COUNT_W'(bpc_pkg::MAX_SLOTS);
    end else begin
      n = cfg.slot_count;
    end
  end

  assign last = bpc_pkg::SLOT_W'(n - bpc_pkg::SLOT_COUNT_W'(1));

  always_comb begin
    for (int i = 0; i < bpc_pkg::MAX_SLOTS; i++) begin
      below[i] = hold < {{(bpc_pkg::TIME_W - bpc_pkg::THR_W){1'b0}}, cfg.thr[i]};
    end
  end

  always_comb begin
    logic done;
    int   k;
    done = 1'b0;
    pick.hit = 1'b0;
    pick.idx = '0;
    // short slots from the bottom, stop at the first long one
    for (int i = 0; i < bpc_pkg::MAX_SLOTS; i++) begin
      if (!done && (i < int'(n))) begin
        if (cfg.long_mask[i]) begin
          done = 1'b1;
        end else if (below[i]) begin
          pick.hit = 1'b1;
          pick.idx = bpc_pkg::SLOT_W'(i);
          done = 1'b1;
        end
      end
    end
    // long slots from the top, stop at the first short one
    done = pick.hit;
    for (int j = 0; j < bpc_pkg::MAX_SLOTS; j++) begin
      k = bpc_pkg::MAX_SLOTS - 1 - j;
      if (!done && (k < int'(n))) begin
        if (!cfg.long_mask[k]) begin
          done = 1'b1;
        end else if (!below[k]) begin
          pick.hit = 1'b1;
          pick.idx = bpc_pkg::SLOT_W'(k);
          done = 1'b1;
        end
      end
    end
    pick.exit_req  = pick.hit & cfg.exit_mask[pick.idx];
    pick.last_long = cfg.long_mask[last];
    pick.last_thr  = cfg.thr[last];
  end

endmodule

FILE: hdl/bpc_step.sv
// ---------------------------------------------------------------------------
// bpc_step: key state and step logic
// Holds mode, time and stamps; computes one result per item and updates
// the state when the item is committed.
// ---------------------------------------------------------------------------
module bpc_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              action,
  input  logic              key_level,
  input  bpc_pkg::cfg_t     cfg,
  output bpc_pkg::result_t  res
);

  bpc_pkg::mode_t              key_mode, key_mode_next;
  logic [bpc_pkg::TIME_W-1:0]  time_now, time_now_next;
  logic [bpc_pkg::TIME_W-1:0]  press_stamp, press_stamp_next;
  logic [bpc_pkg::TIME_W-1:0]  release_stamp, release_stamp_next;
  logic                        wakeup_armed, wakeup_armed_next;
  logic [bpc_pkg::TIME_W-1:0]  wakeup_stamp, wakeup_stamp_next;

  logic [bpc_pkg::TIME_W-1:0]  time_inc;
  logic [bpc_pkg::TIME_W-1:0]  since_wakeup;
  logic                        debouncing;
  logic [bpc_pkg::TIME_W-1:0]  judge_stamp;
  logic [bpc_pkg::TIME_W-1:0]  hold;
  bpc_pkg::pick_t              pick;

  assign time_inc     = time_now + bpc_pkg::TIME_W'(1);
  assign since_wakeup = time_inc - wakeup_stamp;
  assign debouncing   = (key_mode == bpc_pkg::MODE_DEBOUNCE);
  assign judge_stamp  = debouncing ? release_stamp : time_inc;
  assign hold         = judge_stamp - press_stamp;

  bpc_slot_pick u_pick (
    .cfg  (cfg),
    .hold (hold),
    .pick (pick)
  );

  always_comb begin
    logic [bpc_pkg::TIME_W-1:0] stamp;
    key_mode_next      = key_mode;
    time_now_next      = time_now;
    press_stamp_next   = press_stamp;
    release_stamp_next = release_stamp;
    wakeup_armed_next  = wakeup_armed;
    wakeup_stamp_next  = wakeup_stamp;
    res.outcome        = bpc_pkg::OUT_NONE;
    res.slot_index     = '0;
    res.exit_request   = 1'b0;
    res.hold_duration  = '0;
    stamp = (key_mode == bpc_pkg::MODE_RELEASED) ? time_now : press_stamp;

    if (action == bpc_pkg::ACT_KEY) begin
      unique case (key_mode)
        bpc_pkg::MODE_RELEASED, bpc_pkg::MODE_DEBOUNCE: begin
          if (key_level) begin
            press_stamp_next  = stamp;
            key_mode_next     = bpc_pkg::MODE_PRESSED;
            wakeup_armed_next = pick.last_long;
            if (pick.last_long) begin
              wakeup_stamp_next = stamp +
                {{(bpc_pkg::TIME_W - bpc_pkg::THR_W){1'b0}}, pick.last_thr};
            end
          end
        end
        bpc_pkg::MODE_PRESSED: begin
          if (!key_level) begin
            key_mode_next      = bpc_pkg::MODE_DEBOUNCE;
            release_stamp_next = time_now;
            wakeup_armed_next  = 1'b1;
            wakeup_stamp_next  = time_now +
              {{(bpc_pkg::TIME_W - bpc_pkg::DEBOUNCE_W){1'b0}}, cfg.debounce_time};
          end
        end
        bpc_pkg::MODE_HANDLED: begin
          if (!key_level) key_mode_next = bpc_pkg::MODE_RELEASED;
        end
        default: ;
      endcase
    end else begin
      time_now_next = time_inc;
      // expired when the wrapped difference is not negative
      if (wakeup_armed && !since_wakeup[bpc_pkg::TIME_W-1]) begin
        release_stamp_next = judge_stamp;
        res.hold_duration  = hold;
        if (pick.hit) begin
          res.outcome      = bpc_pkg::OUT_FIRED;
          res.slot_index   = pick.idx;
          res.exit_request = pick.exit_req;
        end else begin
          res.outcome = debouncing ? bpc_pkg::OUT_IGNORED : bpc_pkg::OUT_NO_SLOT;
        end
        wakeup_armed_next = 1'b0;
        key_mode_next = debouncing ? bpc_pkg::MODE_RELEASED : bpc_pkg::MODE_HANDLED;
      end
    end
    res.wakeup_pending = wakeup_armed_next;
    res.key_mode_out   = key_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode     <= bpc_pkg::MODE_RELEASED;
      time_now     <= '0;
      wakeup_armed <= 1'b0;
    end else if (en) begin
      key_mode     <= key_mode_next;
      time_now     <= time_now_next;
      wakeup_armed <= wakeup_armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      press_stamp   <= press_stamp_next;
      release_stamp <= release_stamp_next;
      wakeup_stamp  <= wakeup_stamp_next;
    end
  end

endmodule

FILE: dv/button_press_classifier_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// button_press_classifier_tb: self-checking bench for the press classifier
// Streams key events and ticks into the block with random gaps and result
// back-pressure, predicts every result beat with an in-bench copy of the
// classifier state, and compares field by field. The run steps through
// several slot and debounce settings, including the register extremes.
// ---------------------------------------------------------------------------
module button_press_classifier_tb;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic action;
    logic key_level;
  } key_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  bpc_item_if   item_ch ();
  bpc_result_if result_ch ();

  button_press_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  always #4 clk = ~clk;

  // -------------------------------------------------------------------------
  // Classifier shadow: register copies plus key state, updated per beat
  // -------------------------------------------------------------------------
  logic [DEBOUNCE_W-1:0]   cf_debounce = 16'd50;
  logic [SLOT_COUNT_W-1:0] cf_count    = 3'd1;
  logic [MAX_SLOTS-1:0]    cf_long     = '0;
  logic [MAX_SLOTS-1:0]    cf_exit     = '0;
  logic [THR_W-1:0]        cf_thr [MAX_SLOTS];

  mode_t             key_mode    = MODE_RELEASED;
  logic [TIME_W-1:0] now_ticks   = '0;
  logic [TIME_W-1:0] pressed_at  = '0;
  logic [TIME_W-1:0] released_at = '0;
  logic              alarm_on    = 1'b0;
  logic [TIME_W-1:0] alarm_at    = '0;

  key_item_t pending_items[$];     // beats waiting for the driver
  result_t   expected_results[$];  // predicted result beats, oldest first

  int  mismatches   = 0;
  int  queued_total = 0;
  int  cycle_count  = 0;
  bit  src_idle_on  = 1'b0;
  bit  sink_idle_on = 1'b0;
  bit  sink_block   = 1'b0;        // long result-side hold-off, set by stimulus
  int  src_gap;
  int  sink_stall;
  key_item_t next_beat;

  // count of slots actually in use: zero reads as one, above four as four
  function automatic int slots_active();
    int n;
    n = int'(cf_count);
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  // short slots ascending (stop at first long), then long slots descending
  // (stop at first short); -1 when nothing matches
  function automatic int choose_action_slot(logic [TIME_W-1:0] hold);
    int n, i, pick;
    bit done;
    n = slots_active();
    pick = -1;
    done = 1'b0;
    for (i = 0; i < n && !done; i++) begin
      if (cf_long[i]) begin
        done = 1'b1;
      end else if (hold < TIME_W'(cf_thr[i])) begin
        pick = i;
        done = 1'b1;
      end
    end
    if (pick < 0) begin
      done = 1'b0;
      for (i = n - 1; i >= 0 && !done; i--) begin
        if (!cf_long[i]) begin
          done = 1'b1;
        end else if (hold >= TIME_W'(cf_thr[i])) begin
          pick = i;
          done = 1'b1;
        end
      end
    end
    return pick;
  endfunction

  // press handling: long last slot arms the hold wakeup, else disarm
  function automatic void arm_on_press();
    int last;
    last = slots_active() - 1;
    key_mode = MODE_PRESSED;
    if (!cf_long[last]) begin
      alarm_on = 1'b0;
    end else begin
      alarm_on = 1'b1;
      alarm_at = pressed_at + TIME_W'(cf_thr[last]);
    end
  endfunction

  function automatic result_t classify_step(logic act, logic lvl);
    result_t r;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] diff;
    int pick;
    logic debouncing;
    r = '0;
    r.outcome = OUT_NONE;
    if (act == ACT_KEY) begin
      case (key_mode)
        MODE_RELEASED, MODE_DEBOUNCE: begin
          if (lvl) begin
            // a bounce back to pressed keeps the original press stamp
            if (key_mode == MODE_RELEASED) pressed_at = now_ticks;
            arm_on_press();
          end
        end
        MODE_PRESSED: begin
          if (!lvl) begin
            key_mode    = MODE_DEBOUNCE;
            released_at = now_ticks;
            alarm_on    = 1'b1;
            alarm_at    = now_ticks + TIME_W'(cf_debounce);
          end
        end
        default: begin
          if (!lvl) key_mode = MODE_RELEASED;
        end
      endcase
    end else begin
      now_ticks = now_ticks + 1;
      diff = now_ticks - alarm_at;   // wrap-safe: expired when not negative
      if (alarm_on && !diff[TIME_W-1]) begin
        debouncing = (key_mode == MODE_DEBOUNCE);
        if (!debouncing) released_at = now_ticks;
        hold = released_at - pressed_at;
        pick = choose_action_slot(hold);
        if (pick >= 0) begin
          r.outcome      = OUT_FIRED;
          r.slot_index   = pick[SLOT_W-1:0];
          r.exit_request = cf_exit[pick];
        end else begin
          r.outcome = debouncing ? OUT_IGNORED : OUT_NO_SLOT;
        end
        r.hold_duration = hold;
        alarm_on = 1'b0;
        key_mode = debouncing ? MODE_RELEASED : MODE_HANDLED;
      end
    end
    r.wakeup_pending = alarm_on;
    r.key_mode_out   = key_mode;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Gaps: mostly none, some short, a few long
  // -------------------------------------------------------------------------
  function automatic int idle_len(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) idle_len = 0;
    else if (r < 92) idle_len = $urandom_range(1, 3);
    else idle_len = $urandom_range(8, 30);
  endfunction

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // -------------------------------------------------------------------------
  // Driver: one beat in flight, predicted on acceptance, gap after each beat
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid     <= 1'b0;
      item_ch.action    <= ACT_KEY;
      item_ch.key_level <= 1'b0;
      src_gap           <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready)
        expected_results.push_back(classify_step(item_ch.action, item_ch.key_level));
      if (!item_ch.valid || item_ch.ready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_beat          = pending_items.pop_front();
          item_ch.valid     <= 1'b1;
          item_ch.action    <= next_beat.action;
          item_ch.key_level <= next_beat.key_level;
          src_gap           <= idle_len(src_idle_on);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks each result beat, throttles ready
  // -------------------------------------------------------------------------
  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      log_mismatch("result beat with nothing pending", 32'(result_ch.outcome), 0);
    end else begin
      want = expected_results.pop_front();
      if (result_ch.outcome !== want.outcome)
        log_mismatch("outcome", 32'(result_ch.outcome), 32'(want.outcome));
      if (result_ch.slot_index !== want.slot_index)
        log_mismatch("slot_index", 32'(result_ch.slot_index), 32'(want.slot_index));
      if (result_ch.exit_request !== want.exit_request)
        log_mismatch("exit_request", 32'(result_ch.exit_request),
                     32'(want.exit_request));
      if (result_ch.hold_duration !== want.hold_duration)
        log_mismatch("hold_duration", result_ch.hold_duration, want.hold_duration);
      if (result_ch.wakeup_pending !== want.wakeup_pending)
        log_mismatch("wakeup_pending", 32'(result_ch.wakeup_pending),
                     32'(want.wakeup_pending));
      if (result_ch.key_mode_out !== want.key_mode_out)
        log_mismatch("key_mode_out", 32'(result_ch.key_mode_out),
                     32'(want.key_mode_out));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_stall      <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) check_result();
      if (sink_block) begin
        result_ch.ready <= 1'b0;
      end else if (sink_stall != 0) begin
        sink_stall      <= sink_stall - 1;
        result_ch.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        sink_stall      <= idle_len(1'b1);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_item(input logic act, input logic lvl);
    key_item_t k;
    k.action    = act;
    k.key_level = lvl;
    pending_items.push_back(k);
    queued_total++;
  endtask

  // all beats offered and every result back
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_DEBOUNCE:   cf_debounce = data[DEBOUNCE_W-1:0];
      CFG_SLOT_COUNT: cf_count    = data[SLOT_COUNT_W-1:0];
      CFG_LONG_MASK:  cf_long     = data[MAX_SLOTS-1:0];
      CFG_EXIT_MASK:  cf_exit     = data[MAX_SLOTS-1:0];
      CFG_THR_ZERO:   cf_thr[0]   = data;
      CFG_THR_ONE:    cf_thr[1]   = data;
      CFG_THR_TWO:    cf_thr[2]   = data;
      default:        cf_thr[3]   = data;
    endcase
  endtask

  // block must be idle; key state carries over from the previous setting
  task automatic program_config(input logic [15:0] deb, input logic [2:0] cnt,
                                input logic [3:0] lng, input logic [3:0] ext,
                                input logic [23:0] t0, input logic [23:0] t1,
                                input logic [23:0] t2, input logic [23:0] t3);
    wait_drained();
    write_reg(CFG_DEBOUNCE,   {8'd0, deb});
    write_reg(CFG_SLOT_COUNT, {21'd0, cnt});
    write_reg(CFG_LONG_MASK,  {20'd0, lng});
    write_reg(CFG_EXIT_MASK,  {20'd0, ext});
    write_reg(CFG_THR_ZERO,   t0);
    write_reg(CFG_THR_ONE,    t1);
    write_reg(CFG_THR_TWO,    t2);
    write_reg(CFG_THR_THREE,  t3);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One press/hold/release/settle cycle with random content; some are noise,
  // some never release, some bounce back to pressed while debouncing.
  task automatic push_sequence(input int reach, input int dreach);
    int kind, n, i;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++)
        push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      push_item(ACT_KEY, 1'b1);
      if ($urandom_range(0, 3) == 0) push_item(ACT_KEY, 1'b1);   // repeat
      n = $urandom_range(0, reach + 3);
      for (i = 0; i < n; i++) begin
        push_item(ACT_TICK, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 19) == 0) push_item(ACT_KEY, 1'b1);
      end
      if (kind >= 25) begin
        push_item(ACT_KEY, 1'b0);
        if ($urandom_range(0, 7) == 0) push_item(ACT_KEY, 1'b0);
        n = dreach + $urandom_range(0, 2);
        for (i = 0; i < n; i++) begin
          push_item(ACT_TICK, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 24) == 0) push_item(ACT_KEY, 1'b1);   // bounce
        end
      end
    end
  endtask

  // One register setting and its share of random beats. With squeeze set
  // the result side is held off while the first beats pile up.
  task automatic run_phase(input logic [15:0] deb, input logic [2:0] cnt,
                           input logic [3:0] lng, input logic [3:0] ext,
                           input logic [23:0] t0, input logic [23:0] t1,
                           input logic [23:0] t2, input logic [23:0] t3,
                           input int quota, input bit src_on, input bit sink_on,
                           input bit squeeze);
    int start, reach, dreach, i;
    program_config(deb, cnt, lng, ext, t0, t1, t2, t3);
    src_idle_on  = src_on;
    sink_idle_on = sink_on;
    // hold times stay near the thresholds, capped so huge ones stay cheap
    reach = 0;
    for (i = 0; i < slots_active(); i++)
      if (int'(cf_thr[i]) > reach) reach = (int'(cf_thr[i]) > 40) ? 40 : int'(cf_thr[i]);
    dreach = (int'(deb) > 40) ? 40 : int'(deb);
    if (squeeze) sink_block = 1'b1;
    start = queued_total;
    while (queued_total - start < quota) begin
      push_sequence(reach, dreach);
      if (sink_block) begin
        if (queued_total - start >= 40) begin
          repeat (150) @(negedge clk);
          sink_block = 1'b0;
        end
      end else if ($urandom_range(0, 19) == 0) begin
        wait_drained();   // sender pause until everything is back
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  // Directed walk, one char per beat: T tick (level 0), t tick (level 1),
  // P key pressed, R key released. Covers: release while released, repeat
  // while pressed, release while debouncing, bounce back to pressed keeping
  // the stamp, long-slot fire into handled, press while handled, release
  // from handled, debounce fire of a short slot, debounce with no slot
  // matching, and ends pressed so the next setting judges a stale wakeup.
  string directed_keys;
  int    di;

  initial begin
    item_ch.valid     = 1'b0;
    item_ch.action    = ACT_KEY;
    item_ch.key_level = 1'b0;
    result_ch.ready   = 1'b0;
    cf_thr[0] = 24'd1000;
    cf_thr[1] = '0;
    cf_thr[2] = '0;
    cf_thr[3] = '0;
    directed_keys = "TRPPtRRPTtTPTRPRTTPTTtRTTP";

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // slot 0 short (3), slot 1 long (4) with exit; unused slots at extremes
    program_config(16'd2, 3'd2, 4'b0010, 4'b0010, 24'd3, 24'd4, 24'hFFFFFF, 24'd0);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (di = 0; di < directed_keys.len(); di++) begin
      case (directed_keys[di])
        "P":     push_item(ACT_KEY, 1'b1);
        "R":     push_item(ACT_KEY, 1'b0);
        "t":     push_item(ACT_TICK, 1'b1);
        default: push_item(ACT_TICK, 1'b0);
      endcase
    end

    // four slots, two short then two long; stale wakeup lands between them
    run_phase(16'd3, 3'd4, 4'b1100, 4'b1010, 24'd2, 24'd3, 24'd20, 24'd12,
              220, 1'b1, 1'b1, 1'b1);
    // zero debounce, slot count zero reads as one long slot; no idling
    run_phase(16'd0, 3'd0, 4'b0001, 4'b0001, 24'd6, 24'd0, 24'd0, 24'd0,
              150, 1'b0, 1'b0, 1'b0);
    // count above range, all long, threshold zero on slot 0
    run_phase(16'd5, 3'd7, 4'b1111, 4'b1111, 24'd0, 24'd3, 24'd9, 24'd15,
              200, 1'b1, 1'b1, 1'b0);
    // all short, slot 0 can never match, slot 1 always does
    run_phase(16'd2, 3'd2, 4'b0000, 4'b0011, 24'd0, 24'hFFFFFF, 24'd0, 24'd0,
              150, 1'b1, 1'b0, 1'b0);
    // maximum debounce and thresholds: wakeups never expire in this run
    run_phase(16'hFFFF, 3'd3, 4'b0100, 4'b0000, 24'hFFFFFF, 24'd0, 24'hFFFFFF,
              24'hFFFFFF, 80, 1'b1, 1'b1, 1'b0);
    // interleaved long/short: both scans stop at once, no slot ever fires
    run_phase(16'd1, 3'd5, 4'b0101, 4'b0101, 24'd2, 24'd4, 24'd6, 24'd8,
              150, 1'b0, 1'b1, 1'b0);
    // single long slot with zero threshold fires on the first tick
    run_phase(16'd4, 3'd1, 4'b0001, 4'b0000, 24'd0, 24'd5, 24'd10, 24'd15,
              100, 1'b1, 1'b1, 1'b0);
    // three short slots and one long
    run_phase(16'd6, 3'd4, 4'b1000, 4'b0110, 24'd5, 24'd10, 24'd15, 24'd25,
              250, 1'b1, 1'b1, 1'b0);

    wait_drained();
    repeat (10) @(negedge clk);   // catch any stray result beats
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: button_press_classifier.f
hdl/bpc_pkg.sv
hdl/bpc_ifs.sv
hdl/bpc_cfg_regs.sv
hdl/bpc_slot_pick.sv
hdl/bpc_step.sv
hdl/button_press_classifier.sv
dv/button_press_classifier_tb.sv
